/* rtl/wtc_pkg.sv */
// ----------------------------------------------------------------------------
// Whitespace token classifier package
// Shared types, byte codes and keyword tables for the token classifier.
// ----------------------------------------------------------------------------
package wtc_pkg;

  // Token classes as they appear on the result channel.
  typedef enum logic [2:0] {
    TT_IDENT   = 3'd0,
    TT_KEYWORD = 3'd1,
    TT_INTEGER = 3'd2,
    TT_STRING  = 3'd3,
    TT_OPER    = 3'd4,
    TT_PUNCT   = 3'd5,
    TT_UNKNOWN = 3'd6
  } tok_type_t;

  localparam int KW_COUNT = 5;
  localparam int KW_MAXLEN = 6;

  // Byte codes.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keyword spellings: fn, let, if, else, return.
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
    '{8'h66, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6C, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E}
  };
  localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd2, 8'd3, 8'd2, 8'd4, 8'd6};

  // Running description of the token being collected.
  typedef struct packed {
    logic [7:0]          len;
    logic [7:0]          first;
    logic [7:0]          second;
    logic [7:0]          prev;
    logic [KW_COUNT-1:0] kw_alive;
    logic                int_ok;
    logic                id_ok;
  } tok_t;

endpackage

/* rtl/wtc_classify.sv */
// ----------------------------------------------------------------------------
// Token classifier
// Maps a finished token description to its class, in priority order.
// ----------------------------------------------------------------------------
module wtc_classify (
  input  wtc_pkg::tok_t      tok,
  output wtc_pkg::tok_type_t tok_type
);

  logic kw_hit;
  logic one_byte;
  logic two_byte;

  always_comb begin
    kw_hit = 1'b0;
    for (int k = 0; k < wtc_pkg::KW_COUNT; k++) begin
      if (tok.kw_alive[k] && (tok.len == wtc_pkg::KW_LEN[k])) begin
        kw_hit = 1'b1;
      end
    end
  end

  assign one_byte = (tok.len == 8'd1);
  assign two_byte = (tok.len == 8'd2);

  always_comb begin
    if (kw_hit) begin
      tok_type = wtc_pkg::TT_KEYWORD;
    end else if (tok.int_ok && !(one_byte && tok.first == wtc_pkg::CH_MINUS)) begin
      tok_type = wtc_pkg::TT_INTEGER;
    end else if ((tok.len >= 8'd2) && (tok.first == wtc_pkg::CH_QUOTE) &&
                 (tok.prev == wtc_pkg::CH_QUOTE)) begin
      tok_type = wtc_pkg::TT_STRING;
    end else if (tok.id_ok) begin
      tok_type = wtc_pkg::TT_IDENT;
    end else if (one_byte && (tok.first == wtc_pkg::CH_PLUS || tok.first == wtc_pkg::CH_MINUS ||
                              tok.first == wtc_pkg::CH_STAR || tok.first == wtc_pkg::CH_SLASH ||
                              tok.first == wtc_pkg::CH_EQ)) begin
      tok_type = wtc_pkg::TT_OPER;
    end else if (two_byte && (tok.second == wtc_pkg::CH_EQ) &&
                 (tok.first == wtc_pkg::CH_EQ || tok.first == wtc_pkg::CH_BANG)) begin
      tok_type = wtc_pkg::TT_OPER;
    end else if (one_byte && (tok.first == wtc_pkg::CH_LBRACE ||
                              tok.first == wtc_pkg::CH_RBRACE ||
                              tok.first == wtc_pkg::CH_LPAREN ||
                              tok.first == wtc_pkg::CH_RPAREN ||
                              tok.first == wtc_pkg::CH_SEMI ||
                              tok.first == wtc_pkg::CH_COLON)) begin
      tok_type = wtc_pkg::TT_PUNCT;
    end else begin
      tok_type = wtc_pkg::TT_UNKNOWN;
    end
  end

endmodule

/* rtl/whitespace_token_classifier_core.sv */
// ----------------------------------------------------------------------------
// Whitespace token classifier core
// Streaming lexer: splits source bytes into whitespace-separated tokens and
// reports one classified token description per finished token.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Ports                      Beat contents
//  -------  ---  -------------------------  ---------------------------------
//  in_      in   tvalid tready tdata tlast  one source byte, tlast = end of source
//  out_     out  tvalid tready tdata        one finished token description
//
// The block takes one byte per cycle while out_tready is high. An accepted
// beat lands in an input register; from there the lexer state is updated and
// a finished token is written to the output register. Both registers advance
// together, so the sustained rate is one byte per cycle whenever out_tready is
// high. When out_tready is low the output register holds its beat and the
// input register fills, after which in_tready drops. Reset (rst_n low,
// synchronous) empties both registers and returns the line counter to one; a
// beat with tlast set does the same to the lexer state once it has been
// processed.
//
module whitespace_token_classifier_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] ch
  input  logic        in_tlast,    // last byte of the source

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata    // [2:0] token_type, [18:3] line_number,
                                   // [26:19] token_index, [34:27] token_length,
                                   // [39:35] zero
);

  // Input register.
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] ch_r;
  logic       last_r;

  // Lexer state.
  logic          in_token_r, in_token_nxt;
  logic          skip_r, skip_nxt;
  logic [15:0]   line_r, line_nxt;
  logic [7:0]    idx_r, idx_nxt;
  wtc_pkg::tok_t tok_r, tok_nxt;

  // Output register.
  logic                out_vld_r, out_vld_nxt;
  wtc_pkg::tok_type_t  out_type_r;
  logic [15:0]         out_line_r;
  logic [7:0]          out_idx_r;
  logic [7:0]          out_len_r;

  logic               adv;
  logic               is_nl;
  logic               is_sep;
  logic               do_add;
  logic               comment;
  logic               emit;
  wtc_pkg::tok_t      tok_base;
  wtc_pkg::tok_t      tok_add;
  wtc_pkg::tok_t      tok_emit;
  wtc_pkg::tok_type_t emit_type;

  // The processing stage moves whenever it holds a byte and the output
  // register is free or being drained this cycle.
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  assign is_nl  = (ch_r == wtc_pkg::CH_LF);
  assign is_sep = (ch_r == wtc_pkg::CH_SP) || (ch_r == wtc_pkg::CH_TAB) ||
                  (ch_r == wtc_pkg::CH_CR) || (ch_r == wtc_pkg::CH_VT) ||
                  (ch_r == wtc_pkg::CH_FF);

  // Token text bytes are ignored while the rest of a comment line is skipped.
  assign do_add = !is_nl && !is_sep && !skip_r;

  // Append the current byte to the running token. A byte that opens a new
  // token starts from a fresh description with every keyword still possible.
  always_comb begin
    logic c_digit;
    logic c_alpha;
    tok_base = tok_r;
    if (!in_token_r) begin
      tok_base          = '0;
      tok_base.kw_alive = '1;
    end
    c_digit = (ch_r >= 8'h30) && (ch_r <= 8'h39);
    c_alpha = ((ch_r >= 8'h61) && (ch_r <= 8'h7A)) ||
              ((ch_r >= 8'h41) && (ch_r <= 8'h5A)) || (ch_r == 8'h5F);
    tok_add = tok_base;
    for (int k = 0; k < wtc_pkg::KW_COUNT; k++) begin
      if (!((tok_base.len < wtc_pkg::KW_LEN[k]) &&
            (wtc_pkg::KW_TEXT[k][tok_base.len[2:0]] == ch_r))) begin
        tok_add.kw_alive[k] = 1'b0;
      end
    end
    if (tok_base.len == 8'd0) begin
      tok_add.first  = ch_r;
      tok_add.int_ok = (ch_r == wtc_pkg::CH_MINUS) || c_digit;
      tok_add.id_ok  = c_alpha;
    end else begin
      if (tok_base.len == 8'd1) begin
        tok_add.second = ch_r;
      end
      tok_add.int_ok = tok_base.int_ok && c_digit;
      tok_add.id_ok  = tok_base.id_ok && (c_alpha || c_digit);
    end
    tok_add.prev = ch_r;
    tok_add.len  = (tok_base.len == 8'hFF) ? tok_base.len : tok_base.len + 8'd1;
  end

  // A second slash right after a leading slash turns the token into a comment.
  assign comment = (tok_base.len == 8'd1) && (tok_base.first == wtc_pkg::CH_SLASH) &&
                   (ch_r == wtc_pkg::CH_SLASH);

  // A separator or newline closes a pending token; a final text byte closes
  // the token it just joined unless that token became a comment.
  assign emit     = (is_nl || is_sep) ? in_token_r : (do_add && last_r && !comment);
  assign tok_emit = (is_nl || is_sep) ? tok_r : tok_add;

  wtc_classify u_classify (
    .tok      (tok_emit),
    .tok_type (emit_type)
  );

  always_comb begin
    in_token_nxt = in_token_r;
    skip_nxt     = skip_r;
    line_nxt     = line_r;
    idx_nxt      = idx_r;
    tok_nxt      = tok_r;
    if (adv) begin
      if (is_nl || is_sep) begin
        in_token_nxt = 1'b0;
      end else if (do_add) begin
        in_token_nxt = !comment;
        tok_nxt      = tok_add;
        if (comment) begin
          skip_nxt = 1'b1;
        end
      end
      if (emit && (idx_r != 8'hFF)) begin
        idx_nxt = idx_r + 8'd1;
      end
      if (is_nl) begin
        skip_nxt = 1'b0;
        idx_nxt  = '0;
        if (line_r != 16'hFFFF) begin
          line_nxt = line_r + 16'd1;
        end
      end
      // End of source: the next byte starts over at line one.
      if (last_r) begin
        in_token_nxt = 1'b0;
        skip_nxt     = 1'b0;
        line_nxt     = 16'd1;
        idx_nxt      = '0;
      end
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = emit;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      in_token_r <= 1'b0;
      skip_r     <= 1'b0;
      line_r     <= 16'd1;
      idx_r      <= '0;
    end else begin
      in_vld_r   <= in_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      in_token_r <= in_token_nxt;
      skip_r     <= skip_nxt;
      line_r     <= line_nxt;
      idx_r      <= idx_nxt;
    end
  end

  // Payload registers carry no reset; they are only read behind a valid flag.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r   <= in_tdata;
      last_r <= in_tlast;
    end
    tok_r <= tok_nxt;
    if (adv && emit) begin
      out_type_r <= emit_type;
      out_line_r <= line_r;
      out_idx_r  <= idx_r;
      out_len_r  <= tok_emit.len;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_len_r, out_idx_r, out_line_r, out_type_r};

`ifndef SYNTH
  // A comment skip only starts by dropping the token, so both cannot be set.
  a_skip_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(skip_r && in_token_r))
    else $error("skip and pending token set together");

  // Every reported token holds at least one byte.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_len_r != 8'd0))
    else $error("token of zero length reported");

  // The end-of-source byte returns the lexer to its start state.
  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_r) |=> (line_r == 16'd1) && (idx_r == 8'd0) && !in_token_r && !skip_r)
    else $error("lexer state not restarted after final byte");

  // A newline clears the comment skip and the per-line token index.
  a_newline: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_nl) |=> (idx_r == 8'd0) && !skip_r && !in_token_r)
    else $error("newline did not restart the line");

  // Input stalls only while the input register holds an unprocessed byte.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_vld_r && out_vld_r && !out_tready))
    else $error("input stalled without a blocked output");
`endif

endmodule
